[hdl/qaar_pkg.sv]
package qaar_pkg;

  localparam int MAX_W_DEF = 1024;
  localparam int MAX_H_DEF = 1024;

  localparam int CFG_W = 12;
  localparam int IDX_W = 3;
  localparam int PIX_W = 8;
  localparam int SZ_W = 11;
  localparam int PT_W = 19;
  localparam int MID_W = 20;
  localparam int CW = 24;
  localparam int EXT_W = 20;
  localparam int RAW_W = 40;
  localparam int ACC_W = 48;
  localparam int HW = 6;
  localparam int WT_W = 11;
  localparam int SUB_SH = 5;
  localparam int DIV_STEPS = 8;
  localparam int DIV_CNT_W = 3;
  localparam int GUARD_LO = -640000;
  localparam int GUARD_PAD = 10000;

  localparam logic [IDX_W-1:0] REG_SRC_WIDTH = 3'd0;
  localparam logic [IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [IDX_W-1:0] REG_BG_VALUE = 3'd2;
  localparam logic [IDX_W-1:0] REG_MIN_WIDTH = 3'd3;
  localparam logic [IDX_W-1:0] REG_MIN_HEIGHT = 3'd4;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_MAP = 2'd1,
    OP_BG = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_BOX, ST_WIDEN, ST_EDGE, ST_AREA, ST_WALK, ST_BGMUL, ST_BGADD,
    ST_DIV, ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    CMD_NONE, CMD_LOAD, CMD_CAPTURE, CMD_BOX, CMD_WIDEN, CMD_EDGE, CMD_AREA,
    CMD_WALK, CMD_BGMUL, CMD_BGADD, CMD_DIV, CMD_PUT_Q, CMD_PUT_BG
  } cmd_t;

  typedef struct packed {
    logic skip;
    logic clip_empty;
    logic walk_last;
  } status_t;

  typedef struct packed {
    logic signed [PT_W-1:0] ltx;
    logic signed [PT_W-1:0] lty;
    logic signed [PT_W-1:0] lbx;
    logic signed [PT_W-1:0] lby;
    logic signed [PT_W-1:0] rtx;
    logic signed [PT_W-1:0] rty;
    logic signed [PT_W-1:0] rbx;
    logic signed [PT_W-1:0] rby;
  } quad_t;

endpackage

[hdl/quad_area_average_resampler.sv]
// Channel   Dir  Beat contents
// s_*       in   tuser: op; tdata: load_pixel, then the eight grid coordinates
// m_*       out  tdata: pixel_out
// cfg_*     in   register index and write data, one write per cycle
//
// Load and unused beats are handled in the idle state; a background beat goes straight to output.
// A map beat walks each covered source pixel through the single read port of the source store,
// then runs the eight-step quotient unit; a box that gives background skips both.
// Reset clears the load pointer and the registers; the store keeps its contents.
// One result is held at the output; a new beat is taken while it waits.
module quad_area_average_resampler #(
  parameter int MAX_SRC_WIDTH = qaar_pkg::MAX_W_DEF,
  parameter int MAX_SRC_HEIGHT = qaar_pkg::MAX_H_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [159:0]               s_tdata,  // load_pixel, ltx, lty, lbx, lby, rtx, rty, rbx, rby
  input  logic [1:0]                 s_tuser,  // op
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [7:0]                 m_tdata,  // pixel_out
  input  logic                       cfg_we,
  input  logic [qaar_pkg::IDX_W-1:0] cfg_index,
  input  logic [qaar_pkg::CFG_W-1:0] cfg_data
);
  import qaar_pkg::*;

  cmd_t cmd;
  status_t status;
  quad_t quad_in;

  assign quad_in.ltx = s_tdata[26:8];
  assign quad_in.lty = s_tdata[45:27];
  assign quad_in.lbx = s_tdata[64:46];
  assign quad_in.lby = s_tdata[83:65];
  assign quad_in.rtx = s_tdata[102:84];
  assign quad_in.rty = s_tdata[121:103];
  assign quad_in.rbx = s_tdata[140:122];
  assign quad_in.rby = s_tdata[159:141];

  qaar_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .op       (op_t'(s_tuser)),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .status   (status)
  );

  qaar_dp #(
    .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
    .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .load_pixel (s_tdata[7:0]),
    .quad_in    (quad_in),
    .cmd        (cmd),
    .status     (status),
    .pixel_out  (m_tdata)
  );

endmodule

[hdl/qaar_ctrl.sv]
module qaar_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  qaar_pkg::op_t     op,
  output logic              m_tvalid,
  input  logic              m_tready,
  output qaar_pkg::cmd_t    cmd,
  input  qaar_pkg::status_t status
);
  import qaar_pkg::*;

  state_t state, state_next;
  logic bg_res, bg_res_next;
  logic [DIV_CNT_W-1:0] div_cnt, div_cnt_next;
  logic m_valid, m_valid_next;
  logic put;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      bg_res <= 1'b0;
      div_cnt <= '0;
      m_valid <= 1'b0;
    end else begin
      state <= state_next;
      bg_res <= bg_res_next;
      div_cnt <= div_cnt_next;
      m_valid <= m_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    bg_res_next = bg_res;
    div_cnt_next = div_cnt;
    cmd = CMD_NONE;
    s_tready = 1'b0;
    put = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          case (op)
            OP_LOAD: cmd = CMD_LOAD;
            OP_MAP: begin
              cmd = CMD_CAPTURE;
              state_next = ST_BOX;
            end
            OP_BG: begin
              bg_res_next = 1'b1;
              state_next = ST_DONE;
            end
            default: ;
          endcase
        end
      end
      ST_BOX: begin
        cmd = CMD_BOX;
        state_next = ST_WIDEN;
      end
      ST_WIDEN: begin
        cmd = CMD_WIDEN;
        state_next = ST_EDGE;
      end
      ST_EDGE: begin
        cmd = CMD_EDGE;
        state_next = ST_AREA;
      end
      ST_AREA: begin
        if (status.skip) begin
          bg_res_next = 1'b1;
          state_next = ST_DONE;
        end else begin
          cmd = CMD_AREA;
          state_next = status.clip_empty ? ST_BGMUL : ST_WALK;
        end
      end
      ST_WALK: begin
        cmd = CMD_WALK;
        if (status.walk_last) state_next = ST_BGMUL;
      end
      ST_BGMUL: begin
        cmd = CMD_BGMUL;
        state_next = ST_BGADD;
      end
      ST_BGADD: begin
        cmd = CMD_BGADD;
        div_cnt_next = '0;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd = CMD_DIV;
        div_cnt_next = div_cnt + 1'b1;
        if (div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!m_valid || m_tready) begin
          cmd = bg_res ? CMD_PUT_BG : CMD_PUT_Q;
          put = 1'b1;
          bg_res_next = 1'b0;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
    m_valid_next = put | (m_valid & ~m_tready);
  end

  assign m_tvalid = m_valid;

endmodule

[hdl/qaar_dp.sv]
module qaar_dp #(
  parameter int MAX_SRC_WIDTH = qaar_pkg::MAX_W_DEF,
  parameter int MAX_SRC_HEIGHT = qaar_pkg::MAX_H_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [qaar_pkg::IDX_W-1:0]  cfg_index,
  input  logic [qaar_pkg::CFG_W-1:0]  cfg_data,
  input  logic [qaar_pkg::PIX_W-1:0]  load_pixel,
  input  qaar_pkg::quad_t             quad_in,
  input  qaar_pkg::cmd_t              cmd,
  output qaar_pkg::status_t           status,
  output logic [qaar_pkg::PIX_W-1:0]  pixel_out
);
  import qaar_pkg::*;

  localparam int XW = $clog2(MAX_SRC_WIDTH);
  localparam int YW = $clog2(MAX_SRC_HEIGHT);
  localparam int DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
  localparam int AW = $clog2(DEPTH);
  localparam int CXW = $clog2(MAX_SRC_WIDTH * 32 + 1);
  localparam int CYW = $clog2(MAX_SRC_HEIGHT * 32 + 1);
  localparam logic signed [CW-1:0] G_LO = CW'(GUARD_LO);
  localparam logic signed [CW-1:0] G_PAD = CW'(GUARD_PAD);
  localparam logic signed [CW-1:0] ONE = CW'(1);
  localparam logic signed [CW-1:0] SUBPX = CW'(32);

  logic [SZ_W-1:0] src_width, src_height;
  logic [PIX_W-1:0] bg_value;
  logic [CFG_W-1:0] min_w, min_h;
  logic [SZ_W-1:0] sw, sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width <= SZ_W'(1024);
      src_height <= SZ_W'(1024);
      bg_value <= PIX_W'(255);
      min_w <= CFG_W'(32);
      min_h <= CFG_W'(32);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SRC_WIDTH: src_width <= cfg_data[SZ_W-1:0];
        REG_SRC_HEIGHT: src_height <= cfg_data[SZ_W-1:0];
        REG_BG_VALUE: bg_value <= cfg_data[PIX_W-1:0];
        REG_MIN_WIDTH: min_w <= cfg_data;
        REG_MIN_HEIGHT: min_h <= cfg_data;
        default: ;
      endcase
    end
  end

  assign sw = (int'(src_width) > MAX_SRC_WIDTH) ? SZ_W'(MAX_SRC_WIDTH) : src_width;
  assign sh = (int'(src_height) > MAX_SRC_HEIGHT) ? SZ_W'(MAX_SRC_HEIGHT) : src_height;

  // Load pointer.
  logic [AW-1:0] ptr_addr, ptr_base;
  logic [XW-1:0] ptr_col;
  logic [YW-1:0] ptr_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr_addr <= '0;
      ptr_base <= '0;
      ptr_col <= '0;
      ptr_row <= '0;
    end else if (cmd == CMD_LOAD) begin
      if (int'(ptr_col) + 1 >= int'(sw)) begin
        ptr_col <= '0;
        if (int'(ptr_row) + 1 >= int'(sh)) begin
          ptr_row <= '0;
          ptr_base <= '0;
          ptr_addr <= '0;
        end else begin
          ptr_row <= ptr_row + 1'b1;
          ptr_base <= ptr_base + AW'(MAX_SRC_WIDTH);
          ptr_addr <= ptr_base + AW'(MAX_SRC_WIDTH);
        end
      end else begin
        ptr_col <= ptr_col + 1'b1;
        ptr_addr <= ptr_addr + 1'b1;
      end
    end
  end

  // Box geometry.
  quad_t q;
  logic signed [MID_W-1:0] mx [4];
  logic signed [MID_W-1:0] my [4];
  logic signed [MID_W-1:0] lo_x, hi_x, lo_y, hi_y;
  logic signed [MID_W-1:0] lo_x_c, hi_x_c, lo_y_c, hi_y_c;

  always_comb begin
    mx[0] = MID_W'(q.ltx) + MID_W'(q.rtx);
    mx[1] = MID_W'(q.rtx) + MID_W'(q.rbx);
    mx[2] = MID_W'(q.rbx) + MID_W'(q.lbx);
    mx[3] = MID_W'(q.ltx) + MID_W'(q.lbx);
    my[0] = MID_W'(q.lty) + MID_W'(q.rty);
    my[1] = MID_W'(q.rty) + MID_W'(q.rby);
    my[2] = MID_W'(q.rby) + MID_W'(q.lby);
    my[3] = MID_W'(q.lty) + MID_W'(q.lby);
    lo_x_c = mx[0];
    hi_x_c = mx[0];
    lo_y_c = my[0];
    hi_y_c = my[0];
    for (int i = 1; i < 4; i++) begin
      if (mx[i] < lo_x_c) lo_x_c = mx[i];
      if (mx[i] > hi_x_c) hi_x_c = mx[i];
      if (my[i] < lo_y_c) lo_y_c = my[i];
      if (my[i] > hi_y_c) hi_y_c = my[i];
    end
  end

  logic signed [CW-1:0] lx, hx_e, ly, hy_e, mwx, mwy;
  logic signed [CW-1:0] l2, r2, t2, b2;

  assign lx = CW'(lo_x);
  assign hx_e = CW'(hi_x);
  assign ly = CW'(lo_y);
  assign hy_e = CW'(hi_y);
  assign mwx = $signed({{(CW-CFG_W){1'b0}}, min_w});
  assign mwy = $signed({{(CW-CFG_W){1'b0}}, min_h});

  always_ff @(posedge clk) begin
    if (cmd == CMD_CAPTURE) q <= quad_in;
    if (cmd == CMD_BOX) begin
      lo_x <= lo_x_c;
      hi_x <= hi_x_c;
      lo_y <= lo_y_c;
      hi_y <= hi_y_c;
    end
    if (cmd == CMD_WIDEN) begin
      if (hx_e - lx < mwx) begin
        l2 <= lx + hx_e - mwx;
        r2 <= lx + hx_e + mwx;
      end else begin
        l2 <= lx <<< 1;
        r2 <= hx_e <<< 1;
      end
      if (hy_e - ly < mwy) begin
        t2 <= ly + hy_e - mwy;
        b2 <= ly + hy_e + mwy;
      end else begin
        t2 <= ly <<< 1;
        b2 <= hy_e <<< 1;
      end
    end
  end

  logic signed [CW-1:0] sw_s, sh_s, sw32, sh32;
  logic signed [CW-1:0] e_left, e_right, e_top, e_bot;
  logic guard, outside, zero_box;

  assign sw_s = $signed({{(CW-SZ_W){1'b0}}, sw});
  assign sh_s = $signed({{(CW-SZ_W){1'b0}}, sh});
  assign sw32 = sw_s <<< SUB_SH;
  assign sh32 = sh_s <<< SUB_SH;
  assign e_left = l2 >>> 1;
  assign e_right = (r2 + ONE) >>> 1;
  assign e_top = t2 >>> 1;
  assign e_bot = (b2 + ONE) >>> 1;
  assign guard = (t2 < G_LO) || (l2 < G_LO) ||
                 (b2 > ((sh_s + G_PAD) <<< 6)) || (r2 > ((sw_s + G_PAD) <<< 6));
  assign outside = (((e_bot - ONE) >>> SUB_SH) < 0) || (((e_right - ONE) >>> SUB_SH) < 0) ||
                   ((e_left >>> SUB_SH) >= sw_s) || ((e_top >>> SUB_SH) >= sh_s);
  assign zero_box = (e_right == e_left) || (e_bot == e_top);

  logic skip;
  logic [EXT_W-1:0] box_w, box_h;
  logic signed [CW-1:0] cl, cr, ct, cb;

  always_ff @(posedge clk) begin
    if (cmd == CMD_EDGE) begin
      skip <= guard | outside | zero_box;
      box_w <= EXT_W'(e_right - e_left);
      box_h <= EXT_W'(e_bot - e_top);
      cl <= (e_left < 0) ? '0 : e_left;
      cr <= (e_right > sw32) ? sw32 : e_right;
      ct <= (e_top < 0) ? '0 : e_top;
      cb <= (e_bot > sh32) ? sh32 : e_bot;
    end
  end

  // Areas and pixel walk.
  logic [2*EXT_W-1:0] raw_prod;
  logic [CXW-1:0] span_x;
  logic [CYW-1:0] span_y;
  logic [CXW+CYW-1:0] clip_prod;
  logic [RAW_W-1:0] raw, clipped;
  logic signed [CW-1:0] cr_m1, cb_m1;
  logic [XW-1:0] wx, x0, xe;
  logic [YW-1:0] wy, ye;
  logic [AW-1:0] row_base;

  assign raw_prod = box_w * box_h;
  assign span_x = CXW'(cr - cl);
  assign span_y = CYW'(cb - ct);
  assign clip_prod = span_x * span_y;
  assign cr_m1 = cr - ONE;
  assign cb_m1 = cb - ONE;

  logic signed [CW-1:0] px_lo, px_hi, py_lo, py_hi, ax, bx, ay, by;
  logic [HW-1:0] wgt_x, wgt_y;

  assign px_lo = $signed({{(CW-XW-SUB_SH){1'b0}}, wx, {SUB_SH{1'b0}}});
  assign px_hi = px_lo + SUBPX;
  assign py_lo = $signed({{(CW-YW-SUB_SH){1'b0}}, wy, {SUB_SH{1'b0}}});
  assign py_hi = py_lo + SUBPX;
  assign ax = (cl > px_lo) ? cl : px_lo;
  assign bx = (cr < px_hi) ? cr : px_hi;
  assign ay = (ct > py_lo) ? ct : py_lo;
  assign by = (cb < py_hi) ? cb : py_hi;
  assign wgt_x = HW'(bx - ax);
  assign wgt_y = HW'(by - ay);

  logic [PIX_W-1:0] mem [DEPTH];
  logic [PIX_W-1:0] rd_data;
  logic [WT_W-1:0] wgt;
  logic p1;

  always_ff @(posedge clk) begin
    if (cmd == CMD_LOAD) mem[ptr_addr] <= load_pixel;
    rd_data <= mem[row_base + AW'(wx)];
  end

  always_ff @(posedge clk) begin
    if (rst) p1 <= 1'b0;
    else p1 <= (cmd == CMD_WALK);
  end

  always_ff @(posedge clk) begin
    if (cmd == CMD_AREA) begin
      raw <= RAW_W'(raw_prod);
      clipped <= RAW_W'(clip_prod);
      x0 <= cl[SUB_SH +: XW];
      wx <= cl[SUB_SH +: XW];
      xe <= cr_m1[SUB_SH +: XW];
      wy <= ct[SUB_SH +: YW];
      ye <= cb_m1[SUB_SH +: YW];
      row_base <= AW'(AW'(ct[SUB_SH +: YW]) * AW'(MAX_SRC_WIDTH));
    end else if (cmd == CMD_WALK) begin
      wgt <= WT_W'(wgt_x * wgt_y);
      if (wx == xe) begin
        wx <= x0;
        wy <= wy + 1'b1;
        row_base <= row_base + AW'(MAX_SRC_WIDTH);
      end else begin
        wx <= wx + 1'b1;
      end
    end
  end

  assign status.skip = skip;
  assign status.clip_empty = (cr <= cl) || (cb <= ct);
  assign status.walk_last = (wx == xe) && (wy == ye);

  // Accumulate, add background share, divide.
  logic [ACC_W-1:0] acc, bgprod, dsh;
  logic [PIX_W-1:0] quot;
  logic ge;

  assign ge = (acc >= dsh);

  always_ff @(posedge clk) begin
    if (cmd == CMD_AREA) begin
      acc <= '0;
    end else if (p1) begin
      acc <= acc + ACC_W'(rd_data * wgt);
    end else if (cmd == CMD_BGADD) begin
      acc <= acc + bgprod + ACC_W'(raw >> 1);
    end else if (cmd == CMD_DIV && ge) begin
      acc <= acc - dsh;
    end
    if (cmd == CMD_BGMUL) bgprod <= ACC_W'(bg_value * (raw - clipped));
    if (cmd == CMD_BGADD) begin
      dsh <= ACC_W'(raw) << (DIV_STEPS - 1);
      quot <= '0;
    end else if (cmd == CMD_DIV) begin
      dsh <= dsh >> 1;
      quot <= {quot[PIX_W-2:0], ge};
    end
    if (cmd == CMD_PUT_Q) pixel_out <= quot;
    else if (cmd == CMD_PUT_BG) pixel_out <= bg_value;
  end

endmodule

[verif/quad_area_average_resampler_tb.sv]
module quad_area_average_resampler_tb;
  import qaar_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STRIDE = 1024;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct {
    op_t op;
    logic [7:0] pix;
    logic signed [PT_W-1:0] pt[8];
  } beat_t;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [159:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [7:0] m_tdata;
  logic cfg_we = 0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  beat_t pending[$];
  logic [7:0] expected_pix[$];
  logic [7:0] image_mem[int];
  int load_ptr;
  int sh_width, sh_height, sh_bg, sh_minw, sh_minh;
  int errors = 0;
  int cycles = 0;
  int results_seen = 0;
  int maps_sent = 0;
  bit steady = 0;
  bit hold_req = 0;
  bit hold_taken = 0;
  int hold_cnt = 0;

  quad_area_average_resampler DUT (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint floor_half(longint v);
    return v >= 0 ? v / 2 : -((-v + 1) / 2);
  endfunction

  function automatic longint floor32(longint v);
    return v >= 0 ? v / 32 : -((-v + 31) / 32);
  endfunction

  function automatic longint lmin(longint a, longint b);
    return a < b ? a : b;
  endfunction

  function automatic longint lmax(longint a, longint b);
    return a > b ? a : b;
  endfunction

  function automatic int eff_w();
    return sh_width > STRIDE ? STRIDE : sh_width;
  endfunction

  function automatic int eff_h();
    return sh_height > STRIDE ? STRIDE : sh_height;
  endfunction

  function automatic void span(longint q0, longint q1, longint q2, longint q3,
                               longint minv, output longint lo2, output longint hi2);
    longint lo, hi;
    lo = lmin(lmin(q0, q1), lmin(q2, q3));
    hi = lmax(lmax(q0, q1), lmax(q2, q3));
    if (hi - lo < minv) begin
      lo2 = lo + hi - minv;
      hi2 = lo + hi + minv;
    end else begin
      lo2 = 2 * lo;
      hi2 = 2 * hi;
    end
  endfunction

  function automatic logic [7:0] area_average(beat_t b);
    longint l2, r2, t2, b2, lf, rt, tp, bt, sw, sh, raw, clip;
    longint cl, cr, ct, cb, hx, hy, rowsum, total;
    longint p[8];
    for (int i = 0; i < 8; i++) p[i] = b.pt[i];
    sw = eff_w();
    sh = eff_h();
    // Points: ltx lty lbx lby rtx rty rbx rby; edge midpoints are pair sums.
    span(p[0] + p[4], p[4] + p[6], p[6] + p[2], p[0] + p[2], sh_minw, l2, r2);
    span(p[1] + p[5], p[5] + p[7], p[7] + p[3], p[1] + p[3], sh_minh, t2, b2);
    if (t2 < GUARD_LO || l2 < GUARD_LO || b2 > 64 * (sh + GUARD_PAD) ||
        r2 > 64 * (sw + GUARD_PAD))
      return sh_bg[7:0];
    lf = floor_half(l2);
    rt = -floor_half(-r2);
    tp = floor_half(t2);
    bt = -floor_half(-b2);
    if (floor32(bt - 1) < 0 || floor32(rt - 1) < 0 || floor32(lf) >= sw ||
        floor32(tp) >= sh)
      return sh_bg[7:0];
    raw = (rt - lf) * (bt - tp);
    if (raw <= 0) return sh_bg[7:0];
    cl = lmax(lf, 0);
    cr = lmin(rt, sw * 32);
    ct = lmax(tp, 0);
    cb = lmin(bt, sh * 32);
    clip = (cr - cl) * (cb - ct);
    total = 0;
    for (longint y = ct / 32; y <= (cb - 1) / 32; y++) begin
      hy = lmin(cb, (y + 1) * 32) - lmax(ct, y * 32);
      rowsum = 0;
      for (longint x = cl / 32; x <= (cr - 1) / 32; x++) begin
        hx = lmin(cr, (x + 1) * 32) - lmax(cl, x * 32);
        if (image_mem.exists(int'(y * STRIDE + x)))
          rowsum += longint'(image_mem[int'(y * STRIDE + x)]) * hx;
      end
      total += rowsum * hy;
    end
    total += longint'(sh_bg) * (raw - clip);
    return 8'((total + raw / 2) / raw);
  endfunction

  function automatic void apply_beat(beat_t b);
    int addr, col, row;
    case (b.op)
      OP_LOAD: begin
        addr = load_ptr < STRIDE * STRIDE ? load_ptr : 0;
        col = addr % STRIDE;
        row = addr / STRIDE;
        image_mem[addr] = b.pix;
        if (col + 1 >= eff_w()) begin
          col = 0;
          row++;
          if (row >= eff_h()) row = 0;
        end else begin
          col++;
        end
        load_ptr = row * STRIDE + col;
      end
      OP_MAP: expected_pix.push_back(area_average(b));
      OP_BG: expected_pix.push_back(sh_bg[7:0]);
      default: ;
    endcase
  endfunction

  function automatic logic [159:0] pack_beat(beat_t b);
    logic [159:0] d;
    d = '0;
    d[7:0] = b.pix;
    for (int i = 0; i < 8; i++) d[8 + i * PT_W +: PT_W] = b.pt[i];
    return d;
  endfunction

  task automatic report_mismatch(logic [7:0] got, logic [7:0] want);
    $display("MISMATCH at cycle %0d: pixel_out %0d, expected %0d", cycles, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    beat_t b;
    if (rst) begin
      s_tvalid <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        b.op = op_t'(s_tuser);
        b.pix = s_tdata[7:0];
        for (int i = 0; i < 8; i++) b.pt[i] = s_tdata[8 + i * PT_W +: PT_W];
        apply_beat(b);
      end
      if (!s_tvalid || s_tready) begin
        if (pending.size() > 0 && (steady || $urandom_range(99) >= 29)) begin
          b = pending.pop_front();
          s_tvalid <= 1;
          s_tuser <= b.op;
          s_tdata <= pack_beat(b);
        end else begin
          s_tvalid <= 0;
        end
      end
    end
  end

  always @(posedge clk) begin
    logic [7:0] want;
    if (rst) begin
      m_tready <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (expected_pix.size() == 0) begin
          $display("UNEXPECTED beat at cycle %0d: pixel_out %0d", cycles, m_tdata);
          errors++;
        end else begin
          want = expected_pix.pop_front();
          if (m_tdata !== want) report_mismatch(m_tdata, want);
        end
      end
      if (hold_req && !hold_taken) begin
        hold_cnt <= hold_cnt + 1;
        m_tready <= 0;
        if (hold_cnt >= 400) hold_taken <= 1;
      end else begin
        m_tready <= steady || ($urandom_range(99) >= 29);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("quad_area_average_resampler verification failed");
      $finish;
    end
  end

  function automatic beat_t blank(op_t op);
    beat_t b;
    b.op = op;
    b.pix = 8'($urandom);
    for (int i = 0; i < 8; i++) b.pt[i] = PT_W'($urandom);
    return b;
  endfunction

  function automatic beat_t quad_at(int x0, int y0, int x1, int y1);
    beat_t b;
    b = blank(OP_MAP);
    b.pt[0] = x0; b.pt[1] = y0;
    b.pt[2] = x0; b.pt[3] = y1;
    b.pt[4] = x1; b.pt[5] = y0;
    b.pt[6] = x1; b.pt[7] = y1;
    return b;
  endfunction

  function automatic beat_t random_map();
    beat_t b;
    int w16, h16, cx, cy, k;
    w16 = eff_w() * 16;
    h16 = eff_h() * 16;
    k = $urandom_range(99);
    if (k < 8) return blank(OP_MAP);
    if (k < 12) return quad_at(0, 0, w16, h16);
    if (k < 18) begin
      cx = $urandom_range(w16 + 64) - 32;
      cy = $urandom_range(h16 + 64) - 32;
      return quad_at(cx, cy, cx, cy);
    end
    b = blank(OP_MAP);
    cx = $urandom_range(w16 + 96) - 48;
    cy = $urandom_range(h16 + 96) - 48;
    for (int i = 0; i < 8; i += 2) begin
      b.pt[i] = cx + $urandom_range(48) - 24;
      b.pt[i + 1] = cy + $urandom_range(48) - 24;
    end
    return b;
  endfunction

  task automatic write_regs(int w, int h, int bg, int mw, int mh);
    int vals[5];
    vals = '{w, h, bg, mw, mh};
    for (int i = 0; i < 5; i++) begin
      @(posedge clk);
      cfg_we <= 1;
      cfg_index <= IDX_W'(i);
      cfg_data <= CFG_W'(vals[i]);
    end
    @(posedge clk);
    cfg_we <= 0;
    sh_width = w; sh_height = h; sh_bg = bg; sh_minw = mw; sh_minh = mh;
  endtask

  task automatic drain();
    while (pending.size() > 0 || s_tvalid || expected_pix.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic run_phase(int w, int h, int bg, int mw, int mh, int nmaps);
    beat_t b;
    write_regs(w, h, bg, mw, mh);
    for (int i = 0; i < eff_w() * eff_h(); i++) pending.push_back(blank(OP_LOAD));
    for (int i = 0; i < nmaps; i++) begin
      b = random_map();
      if ($urandom_range(99) < 8) b = blank(op_t'($urandom_range(3) == 0 ? OP_NONE : OP_BG));
      else maps_sent++;
      pending.push_back(b);
    end
    drain();
  endtask

  initial begin
    sh_width = 1024; sh_height = 1024; sh_bg = 255; sh_minw = 32; sh_minh = 32;
    load_ptr = 0;
    repeat (3) @(posedge clk);
    rst <= 0;

    // Reset values, with background and unused beats and boxes near or past the source edges.
    pending.push_back(blank(OP_BG));
    pending.push_back(blank(OP_NONE));
    pending.push_back(quad_at(-262144, -262144, -262144, -262144));
    pending.push_back(quad_at(262143, 262143, 262143, 262143));
    pending.push_back(quad_at(-262144, 0, 262143, 100));
    pending.push_back(quad_at(-400, -400, -100, -100));
    pending.push_back(quad_at(-8, 2000, -1, 2100));
    drain();

    write_regs(16, 8, 0, 0, 0);
    for (int i = 0; i < 128; i++) pending.push_back(blank(OP_LOAD));
    pending.push_back(quad_at(0, 0, 256, 128));
    pending.push_back(quad_at(40, 40, 40, 40));
    pending.push_back(quad_at(-40, -40, 3, 5));
    pending.push_back(quad_at(250, 120, 300, 200));
    pending.push_back(quad_at(7, 9, 13, 22));
    pending.push_back(quad_at(-10000, -10000, 20000, 20000));
    pending.push_back(quad_at(-9999, 0, 0, 16));
    pending.push_back(blank(OP_BG));
    pending.push_back(blank(OP_NONE));
    drain();

    steady = 1;
    run_phase(1, 1, 255, 0, 0, 60);
    steady = 0;

    // Width above the maximum: boxes past the last stored column lie outside.
    write_regs(2047, 1, 200, 0, 0);
    for (int i = 0; i < 6; i++)
      pending.push_back(quad_at(16 * (1024 + 40 * i), 0, 16 * (1030 + 40 * i), 16));
    pending.push_back(blank(OP_BG));
    maps_sent += 6;
    drain();

    run_phase(3, 40, 17, 2048, 0, 40);

    write_regs(0, 0, 99, 32, 32);
    for (int i = 0; i < 4; i++) pending.push_back(blank(OP_LOAD));
    for (int i = 0; i < 20; i++) pending.push_back(random_map());
    maps_sent += 20;
    drain();

    // Output held off while the input keeps offering beats.
    write_regs(12, 10, 128, 16, 48);
    for (int i = 0; i < 120; i++) pending.push_back(blank(OP_LOAD));
    for (int i = 0; i < 40; i++) pending.push_back(blank(OP_BG));
    hold_req = 1;
    drain();

    for (int ph = 0; ph < 5; ph++)
      run_phase($urandom_range(16, 1), $urandom_range(12, 1), $urandom_range(255),
                $urandom_range(2048), $urandom_range(2048), 80);

    $display("Covered %0d map beats and %0d result beats over several image sizes,",
             maps_sent, results_seen);
    $display("register settings, guard, outside and empty boxes, and output stalls.");
    if (errors == 0) begin
      $display("quad_area_average_resampler verification clean");
    end else begin
      $display("quad_area_average_resampler verification failed");
    end
    $finish;
  end

endmodule
